// File: rtl/block_bitmap_allocator_defines.svh
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shorthand for the concurrent checks at the end of the allocator top level.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Field widths, status codes, sequencer steps and the microcode table.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAP_BYTES_DEFAULT = 1024;
    localparam int ROW_BYTES         = 16;
    localparam int ROW_BITS          = ROW_BYTES * 8;
    localparam int ROW_SEL_W         = $clog2(ROW_BITS);
    localparam int IDX_W             = 13;
    localparam int CNT_W             = 14;
    localparam int INDEX_SPAN        = 8192;

    localparam logic [CNT_W-1:0] USABLE_RESET = 14'd7931;
    localparam logic [CNT_W-1:0] COUNT_MAX    = '1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_CNT,
        S_SCAN,
        S_PICK,
        S_NOFREE,
        S_ALLOC,
        S_REL,
        S_RELRD,
        S_RELWR,
        S_RANGE,
        S_EMIT
    } step_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACCEPT,
        C_RELEASE,
        C_CNT_ZERO,
        C_SCAN_END,
        C_FIT,
        C_RANGE,
        C_OUT_FREE
    } cond_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_DEC,
        CNT_INC
    } cnt_op_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_NOFREE,
        RES_RANGE,
        RES_OK,
        RES_ALLOC
    } res_t;

    // One control word per sequencer step. When cond is true the sequencer
    // jumps to target; otherwise it stays (stay set) or steps forward.
    typedef struct packed {
        cond_t   cond;
        step_t   target;
        logic    stay;
        logic    mem_rd;
        logic    rd_idx;
        logic    addr_clr;
        logic    scan;
        logic    mem_wr;
        logic    wr_clr;
        cnt_op_t cnt_op;
        res_t    res;
        logic    emit;
    } ctrl_t;

    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '0;
        c.cond   = C_NEVER;
        c.target = S_IDLE;
        c.cnt_op = CNT_HOLD;
        c.res    = RES_NONE;
        case (s)
            S_IDLE:
            begin
                c.cond   = C_ACCEPT;
                c.target = S_DISP;
                c.stay   = 1'b1;
            end
            S_DISP:
            begin
                c.cond   = C_RELEASE;
                c.target = S_REL;
            end
            S_CNT:
            begin
                c.cond     = C_CNT_ZERO;
                c.target   = S_NOFREE;
                c.addr_clr = 1'b1;
            end
            S_SCAN:
            begin
                c.cond   = C_SCAN_END;
                c.target = S_PICK;
                c.stay   = 1'b1;
                c.mem_rd = 1'b1;
                c.scan   = 1'b1;
            end
            S_PICK:
            begin
                c.cond   = C_FIT;
                c.target = S_ALLOC;
            end
            S_NOFREE:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_EMIT;
                c.res    = RES_NOFREE;
            end
            S_ALLOC:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_EMIT;
                c.mem_wr = 1'b1;
                c.cnt_op = CNT_DEC;
                c.res    = RES_ALLOC;
            end
            S_REL:
            begin
                c.cond   = C_RANGE;
                c.target = S_RANGE;
            end
            S_RELRD:
            begin
                c.mem_rd = 1'b1;
                c.rd_idx = 1'b1;
            end
            S_RELWR:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_EMIT;
                c.mem_wr = 1'b1;
                c.wr_clr = 1'b1;
                c.cnt_op = CNT_INC;
                c.res    = RES_OK;
            end
            S_RANGE:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_EMIT;
                c.res    = RES_RANGE;
            end
            S_EMIT:
            begin
                c.cond   = C_OUT_FREE;
                c.target = S_IDLE;
                c.stay   = 1'b1;
                c.emit   = 1'b1;
            end
            default:
            begin
                c.cond   = C_ALWAYS;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

// File: rtl/block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit allocator over a one-bit-per-block use map with a free count.
// ----------------------------------------------------------------------------
// One request at a time is worked by a small microcoded sequencer. A release
// steps through S_REL, S_RELRD and S_RELWR to S_EMIT, or from S_REL through
// S_RANGE to S_EMIT when the index lies out of range. An allocate scans the map
// from the lowest row, one 128-bit row (16 bytes) per cycle through the single
// read port of the map memory, and stops at the first row that holds a free bit
// or at the last row; a request that finds the free count at zero skips the
// scan. A new request is taken while the previous result still waits on the
// master side. Each map row has a valid flag cleared at reset, so the map reads
// as all free right after reset with no clearing pass. A write of usable_blocks
// reloads the free count and leaves the map as it is.
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator #(
    parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [12:0] block_index
    input  logic [0:0]  s_tuser,    // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [12:0] allocated_index, [26:13] free_remaining
    output logic [1:0]  m_tuser,    // [1:0] status
    input  logic        cfg_we,
    input  logic [13:0] cfg_wdata   // usable_blocks
);

    localparam int ROW_BITS  = bba_pkg::ROW_BITS;
    localparam int ROW_SEL_W = bba_pkg::ROW_SEL_W;
    localparam int IDX_W     = bba_pkg::IDX_W;
    localparam int CNT_W     = bba_pkg::CNT_W;
    localparam int MAP_BITS  = MAP_BYTES * 8;
    localparam int ROWS      = (MAP_BYTES + bba_pkg::ROW_BYTES - 1) / bba_pkg::ROW_BYTES;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W    = $clog2(ROWS + 1);
    localparam int POS_W     = ROW_W + ROW_SEL_W;
    localparam int LIM_CAP   = (MAP_BITS < bba_pkg::INDEX_SPAN) ? MAP_BITS : bba_pkg::INDEX_SPAN;
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int IDX_EXT_W = (POS_W > IDX_W) ? POS_W : IDX_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    // Lowest clear bit of a row, found by halving the window each step.
    function automatic logic [ROW_SEL_W-1:0] first_zero(logic [ROW_BITS-1:0] v);
        logic [ROW_BITS-1:0]  w;
        logic [ROW_SEL_W-1:0] p;
        w = ~v;
        p = '0;
        for (int k = ROW_SEL_W - 1; k >= 0; k--)
        begin
            if ((w & ((ROW_BITS'(1) << (1 << k)) - ROW_BITS'(1))) == '0)
            begin
                w    = w >> (1 << k);
                p[k] = 1'b1;
            end
        end
        return p;
    endfunction

    function automatic logic [CNT_W-1:0] limit_of(logic [CNT_W-1:0] usable);
        logic [CNT_W-1:0] m;
        m = usable;
        if (CNT_W'(LIM_CAP) < m)
        begin
            m = CNT_W'(LIM_CAP);
        end
        return m;
    endfunction

    bba_pkg::step_t   upc_reg, upc_next;
    bba_pkg::ctrl_t   cw;
    logic             cond_true;
    logic             accept;

    logic             op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] lim_reg;
    logic [CNT_W-1:0] free_cnt_reg;

    logic [ROW_BITS-1:0] map_mem [ROWS];
    logic [ROWS-1:0]     row_valid_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                pend_reg;
    logic                hit_reg;
    logic [POS_W-1:0]    pos_reg;

    logic                 rd_en;
    logic [ROW_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [ROW_BITS-1:0]  wr_data;
    logic [ROW_BITS-1:0]  wr_mask;
    logic [ROW_BITS-1:0]  cur_row;
    logic                 row_hit;
    logic                 bit_was_set;
    logic                 load_out;
    logic [IDX_EXT_W-1:0] idx_ext;
    logic [ROW_W-1:0]     idx_row;

    bba_pkg::status_t res_status_reg;
    logic [IDX_W-1:0] res_alloc_reg;

    logic             m_valid_reg;
    bba_pkg::status_t m_status_reg;
    logic [IDX_W-1:0] m_alloc_reg;
    logic [CNT_W-1:0] m_free_reg;

    assign cw       = bba_pkg::ucode(upc_reg);
    assign s_tready = (upc_reg == bba_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // A row never written since reset reads as all blocks free.
    assign cur_row = rd_valid_reg ? rd_data_reg : '0;
    assign row_hit = ~&cur_row;
    assign idx_ext = IDX_EXT_W'(idx_reg);
    assign idx_row = idx_ext[POS_W-1:ROW_SEL_W];

    always_comb
    begin
        case (cw.cond)
            bba_pkg::C_NEVER:    cond_true = 1'b0;
            bba_pkg::C_ALWAYS:   cond_true = 1'b1;
            bba_pkg::C_ACCEPT:   cond_true = accept;
            bba_pkg::C_RELEASE:  cond_true = op_reg;
            bba_pkg::C_CNT_ZERO: cond_true = (free_cnt_reg == '0);
            bba_pkg::C_SCAN_END: cond_true = pend_reg && (row_hit || row_reg == LAST_ROW);
            bba_pkg::C_FIT:      cond_true = hit_reg && (CMP_W'(pos_reg) < CMP_W'(lim_reg));
            bba_pkg::C_RANGE:    cond_true = ({1'b0, idx_reg} >= lim_reg);
            bba_pkg::C_OUT_FREE: cond_true = !m_valid_reg || m_tready;
            default:             cond_true = 1'b0;
        endcase
    end

    // Next step of the sequencer.
    always_comb
    begin
        if (cond_true)
        begin
            upc_next = cw.target;
        end
        else if (cw.stay)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = bba_pkg::step_t'(upc_reg + 4'd1);
        end
    end

    // Datapath strobes decoded from the control word.
    always_comb
    begin
        rd_en    = cw.mem_rd && !cond_true;
        rd_addr  = cw.rd_idx ? idx_row : addr_reg[ROW_W-1:0];
        wr_en    = cw.mem_wr;
        wr_mask  = ROW_BITS'(1) << (cw.wr_clr ? idx_reg[ROW_SEL_W-1:0]
                                              : pos_reg[ROW_SEL_W-1:0]);
        wr_data  = cw.wr_clr ? (cur_row & ~wr_mask) : (cur_row | wr_mask);
        bit_was_set = |(cur_row & wr_mask);
        load_out = cw.emit && cond_true;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= bba_pkg::S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser[0];
            idx_reg <= s_tdata[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg      <= limit_of(bba_pkg::USABLE_RESET);
            free_cnt_reg <= bba_pkg::USABLE_RESET;
        end
        else if (cfg_we)
        begin
            lim_reg      <= limit_of(cfg_wdata);
            free_cnt_reg <= cfg_wdata;
        end
        else
        begin
            case (cw.cnt_op)
                bba_pkg::CNT_DEC:
                begin
                    free_cnt_reg <= free_cnt_reg - CNT_W'(1);
                end
                bba_pkg::CNT_INC:
                begin
                    if (bit_was_set && free_cnt_reg != bba_pkg::COUNT_MAX)
                    begin
                        free_cnt_reg <= free_cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            pend_reg <= rd_en;
            if (cw.addr_clr)
            begin
                addr_reg <= '0;
            end
            else if (rd_en && !cw.rd_idx)
            begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            if (wr_en)
            begin
                row_valid_reg[row_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            row_reg      <= rd_addr;
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (cw.scan)
        begin
            hit_reg <= pend_reg && row_hit;
            pos_reg <= {row_reg, first_zero(cur_row)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[row_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        case (cw.res)
            bba_pkg::RES_NOFREE:
            begin
                res_status_reg <= bba_pkg::ST_NOFREE;
                res_alloc_reg  <= '0;
            end
            bba_pkg::RES_RANGE:
            begin
                res_status_reg <= bba_pkg::ST_RANGE;
                res_alloc_reg  <= '0;
            end
            bba_pkg::RES_OK:
            begin
                res_status_reg <= bba_pkg::ST_OK;
                res_alloc_reg  <= '0;
            end
            bba_pkg::RES_ALLOC:
            begin
                res_status_reg <= bba_pkg::ST_OK;
                res_alloc_reg  <= IDX_W'(pos_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_status_reg <= res_status_reg;
            m_alloc_reg  <= res_alloc_reg;
            m_free_reg   <= free_cnt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_free_reg, m_alloc_reg};
    assign m_tuser  = m_status_reg;

    `BBA_ASSERT_NOW(a_scan_in_map, clk, rst_n, rd_en && !cw.rd_idx, addr_reg < ADDR_W'(ROWS), "scan read past the last map row")
    `BBA_ASSERT_NEXT(a_alloc_count, clk, rst_n, upc_reg == bba_pkg::S_ALLOC && !cfg_we, free_cnt_reg == $past(free_cnt_reg) - CNT_W'(1), "allocate did not lower the free count")
    `BBA_ASSERT_NEXT(a_row_marked, clk, rst_n, wr_en, row_valid_reg[$past(row_reg)], "written map row not marked valid")

endmodule
